[hw/rtl/delimited_command_frame_receiver_defines.svh]
// ----------------------------------------------------------------------------
// Delimited command frame receiver: assertion macros
// Shared property macros; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_COMMAND_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on clk, off during rst
`define DCFR_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("dcfr: same-cycle check failed");
// next-cycle implication
`define DCFR_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("dcfr: next-cycle check failed");
`else
`define DCFR_ASSERT_IMP(lbl, ant, cons)
`define DCFR_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

[hw/rtl/dcfr_pkg.sv]
// ----------------------------------------------------------------------------
// dcfr_pkg
// Types and constants shared by the command frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfr_pkg;

  localparam int unsigned MAX_CMD_BYTES_DFLT = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] BEGIN_TAG_RST = 8'd35;
  localparam logic [BYTE_W-1:0] END_TAG_RST   = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEGIN_TAG = 2'd0,
    REG_END_TAG   = 2'd1
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/dcfr_store.sv]
// ----------------------------------------------------------------------------
// dcfr_store
// Command byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfr_store #(
  parameter int unsigned DEPTH = dcfr_pkg::MAX_CMD_BYTES_DFLT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [dcfr_pkg::BYTE_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [dcfr_pkg::BYTE_W-1:0] rdata
);
  import dcfr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcfr_out.sv]
// ----------------------------------------------------------------------------
// dcfr_out
// Two-entry result buffer in front of the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfr_out (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire dcfr_pkg::res_t               push_res,
  output logic      [1:0]                   fill,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [dcfr_pkg::KIND_W-1:0]  kind,
  output logic      [dcfr_pkg::BYTE_W-1:0]  data,
  output logic      [dcfr_pkg::COUNT_W-1:0] count,
  output logic                              last
);
  import dcfr_pkg::*;

  res_t       slot0;
  res_t       slot1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       pop;

  assign pop      = (cnt != 2'd0) && !out_stall;
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // slot0 is the head; slot1 only fills behind a waiting head
  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      slot0 <= slot1;
    end else if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      slot0 <= push_res;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      slot1 <= push_res;
    end
  end

  assign fill      = cnt;
  assign out_valid = (cnt != 2'd0);
  assign kind      = slot0.kind;
  assign data      = slot0.data;
  assign count     = slot0.count;
  assign last      = slot0.last;

endmodule

`default_nettype wire

[hw/rtl/delimited_command_frame_receiver.sv]
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver
// Collects begin/end tagged command frames into a byte store and replays them.
// ----------------------------------------------------------------------------
// Channels: input (in_valid/in_stall, rx_byte), one serial byte per request;
//   output (out_valid/out_stall, kind/data/count/last); config (cfg_valid/
//   cfg_ready, cfg_index/cfg_data): index 0 is the begin tag, index 1 the
//   end tag, other indexes are dropped. Always ready.
// Stalls: a byte that causes no result does not stall. An overflow byte moves
//   to the error state, which holds in_stall until its error is pushed. An
//   end tag over stored bytes holds in_stall while they are read and pushed
//   and until the end result is pushed; store reads are paced by the
//   two-entry result buffer.
// Reset: rst (synchronous) returns to idle, empties the result buffer and
//   loads the tags with '#' and newline. The store needs no clearing.
// Backpressure: out_stall holds the head result; the drain pauses once the
//   two-entry result buffer is full and resumes without loss.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delimited_command_frame_receiver_defines.svh"

module delimited_command_frame_receiver #(
  parameter int unsigned MAX_CMD_BYTES = dcfr_pkg::MAX_CMD_BYTES_DFLT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dcfr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [dcfr_pkg::KIND_W-1:0]    kind,
  output logic      [dcfr_pkg::BYTE_W-1:0]    data,
  output logic      [dcfr_pkg::COUNT_W-1:0]   count,
  output logic                                last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dcfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dcfr_pkg::BYTE_W-1:0]    cfg_data
);
  import dcfr_pkg::*;

  localparam int unsigned ADDR_W = (MAX_CMD_BYTES > 1) ? $clog2(MAX_CMD_BYTES) : 1;
  localparam logic [COUNT_W-1:0] MAX_FILL = COUNT_W'(MAX_CMD_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RECV  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [BYTE_W-1:0]  begin_tag;
  logic [BYTE_W-1:0]  end_tag;
  logic [COUNT_W-1:0] fill_count;
  logic [COUNT_W-1:0] fill_count_next;
  logic [COUNT_W-1:0] drain_len;
  logic [COUNT_W-1:0] drain_len_next;
  logic [COUNT_W-1:0] rd_idx;
  logic [COUNT_W-1:0] rd_idx_next;
  logic               rd_pending;

  logic               in_acc;
  logic               end_hit;
  logic               mem_we;
  logic               mem_re;
  logic [BYTE_W-1:0]  mem_rdata;
  logic [1:0]         ob_fill;
  logic               push;
  res_t               push_res;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_tag <= BEGIN_TAG_RST;
      end_tag   <= END_TAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BEGIN_TAG: begin_tag <= cfg_data;
        REG_END_TAG:   end_tag   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  assign in_stall = !(state == ST_IDLE || state == ST_RECV);
  assign in_acc   = in_valid && !in_stall;
  assign end_hit  = in_acc && rx_byte == end_tag;

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    drain_len_next  = drain_len;
    rd_idx_next     = rd_idx;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    push            = 1'b0;
    push_res        = '{kind: KIND_BYTE, data: mem_rdata, count: '0, last: 1'b0};

    // read data from last cycle always has a buffer slot reserved
    if (rd_pending) begin
      push = 1'b1;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_acc && rx_byte == begin_tag) begin
          state_next      = ST_RECV;
          fill_count_next = '0;
        end
      end
      ST_RECV: begin
        if (in_acc) begin
          if (end_hit) begin
            state_next      = ST_DRAIN;
            drain_len_next  = fill_count;
            rd_idx_next     = '0;
            fill_count_next = '0;
          end else if (fill_count < MAX_FILL) begin
            mem_we          = 1'b1;
            fill_count_next = fill_count + COUNT_W'(1);
          end else begin
            state_next      = ST_ERR;
            fill_count_next = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_idx != drain_len) begin
          if ((ob_fill + 2'(rd_pending)) < 2'd2) begin
            mem_re      = 1'b1;
            rd_idx_next = rd_idx + COUNT_W'(1);
          end
        end else if (!rd_pending && ob_fill < 2'd2) begin
          push       = 1'b1;
          push_res   = '{kind: KIND_END, data: '0, count: drain_len, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (ob_fill < 2'd2) begin
          push       = 1'b1;
          push_res   = '{kind: KIND_OVERFLOW, data: '0, count: '0, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      drain_len  <= '0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      drain_len  <= drain_len_next;
      rd_idx     <= rd_idx_next;
      rd_pending <= mem_re;
    end
  end

  // ---------------- datapath ----------------
  dcfr_store #(
    .DEPTH (MAX_CMD_BYTES),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (mem_re),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  dcfr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .fill      (ob_fill),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .count     (count),
    .last      (last)
  );

  // ---------------- checks ----------------
  `DCFR_ASSERT_IMP(a_fill_in_range, 1'b1, fill_count <= MAX_FILL)
  `DCFR_ASSERT_IMP(a_pending_has_room, rd_pending, ob_fill < 2'd2)
  `DCFR_ASSERT_IMP(a_end_order, push_res.kind == KIND_END, rd_idx == drain_len && !rd_pending)
  `DCFR_ASSERT_NXT(a_drain_start, state == ST_RECV && end_hit, state == ST_DRAIN && rd_idx == '0)
  `DCFR_ASSERT_IMP(a_no_write_while_draining, mem_we, state == ST_RECV && !rd_pending)

endmodule

`default_nettype wire
